// ===== src/imu_sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser package
// Shared types, codes and the angle scaling function.
// ----------------------------------------------------------------------------
package imu_sfp_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   // Slot of the checksum byte; data slots run from one up to nine.
   localparam logic [3:0] CHECK_POS   = 4'd10;

   localparam int          CSR_INDEX_WIDTH = 8;
   localparam logic [7:0]  REG_ACCEL_CODE  = 8'd0;
   localparam logic [7:0]  REG_GYRO_CODE   = 8'd1;
   localparam logic [7:0]  REG_ANGLE_CODE  = 8'd2;

   localparam logic [7:0]  ACCEL_CODE_RESET = 8'd81;
   localparam logic [7:0]  GYRO_CODE_RESET  = 8'd82;
   localparam logic [7:0]  ANGLE_CODE_RESET = 8'd83;

   localparam logic signed [26:0] ANGLE_SCALE = 27'sd1800;
   localparam logic signed [26:0] ANGLE_ROUND = 27'sd32767;

   typedef enum logic [2:0] {
      STATUS_ACCEL   = 3'd0,
      STATUS_GYRO    = 3'd1,
      STATUS_ANGLE   = 3'd2,
      STATUS_UNKNOWN = 3'd3,
      STATUS_BAD_SUM = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] accel_code;
      logic [7:0] gyro_code;
      logic [7:0] angle_code;
   } codes_type;

   typedef struct packed {
      logic               at_check;
      logic [7:0]         sum;
      logic [7:0]         type_code;
      logic signed [15:0] word_zero;
      logic signed [15:0] word_one;
      logic signed [15:0] word_two;
      logic signed [15:0] word_three;
   } frame_type;

   // raw * 1800 / 32768, truncated toward zero. The product stays within
   // 27 signed bits, and the quotient is bits 26 down to 15.
   function automatic logic signed [11:0] to_tenths(input logic signed [15:0] raw);
      logic signed [26:0] prod;
      logic signed [26:0] biased;
      prod   = 27'(raw) * ANGLE_SCALE;
      biased = prod[26] ? prod + ANGLE_ROUND : prod;
      return biased[26:15];
   endfunction

endpackage

// ===== src/imu_sfp_collector.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser: frame collector
// Hunts for the header, stores the frame bytes and keeps a running checksum.
// ----------------------------------------------------------------------------
module imu_sfp_collector
   import imu_sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output frame_type  frame
);

   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] frame_ff [1:9];

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (accept) begin
         if (pos_ff == 4'd0) begin
            if (rx_byte == HEADER_BYTE) begin
               pos_in = 4'd1;
               sum_in = rx_byte;
            end
         end else if (pos_ff < CHECK_POS) begin
            pos_in = pos_ff + 4'd1;
            sum_in = sum_ff + rx_byte;
         end else begin
            pos_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
      end else begin
         pos_ff <= pos_in;
      end
      sum_ff <= sum_in;
      if (accept && pos_ff != 4'd0 && pos_ff < CHECK_POS) begin
         frame_ff[pos_ff] <= rx_byte;
      end
   end

   assign frame.at_check   = (pos_ff == CHECK_POS);
   assign frame.sum        = sum_ff;
   assign frame.type_code  = frame_ff[1];
   assign frame.word_zero  = {frame_ff[3], frame_ff[2]};
   assign frame.word_one   = {frame_ff[5], frame_ff[4]};
   assign frame.word_two   = {frame_ff[7], frame_ff[6]};
   assign frame.word_three = {frame_ff[9], frame_ff[8]};

endmodule

// ===== src/imu_sfp_decoder.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser: frame decoder
// Checks the sum, classifies the frame, keeps angles and counters, and holds
// the result register.
// ----------------------------------------------------------------------------
module imu_sfp_decoder
   import imu_sfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   input  frame_type          frame,
   input  codes_type          codes,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [2:0]         rsp_frame_status,
   output logic signed [15:0] rsp_word_zero,
   output logic signed [15:0] rsp_word_one,
   output logic signed [15:0] rsp_word_two,
   output logic signed [15:0] rsp_word_three,
   output logic signed [11:0] rsp_roll_tenths,
   output logic signed [11:0] rsp_pitch_tenths,
   output logic signed [11:0] rsp_yaw_tenths,
   output logic [31:0]        rsp_bytes_received,
   output logic [31:0]        rsp_angle_frames_seen
);

   logic               valid_ff, valid_in;
   logic [31:0]        byte_cnt_ff, byte_cnt_in;
   logic [31:0]        angle_cnt_ff, angle_cnt_in;
   logic signed [11:0] roll_ff, roll_in;
   logic signed [11:0] pitch_ff, pitch_in;
   logic signed [11:0] yaw_ff, yaw_in;
   status_type         status_ff, status_in;
   logic signed [15:0] w0_ff, w1_ff, w2_ff, w3_ff;
   logic signed [11:0] out_roll_ff, out_pitch_ff, out_yaw_ff;
   logic [31:0]        out_bytes_ff, out_angles_ff;
   logic               load;

   assign load = accept && frame.at_check;

   always_comb begin
      byte_cnt_in  = accept ? byte_cnt_ff + 32'd1 : byte_cnt_ff;
      angle_cnt_in = angle_cnt_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      // Codes that are equal resolve in the order accel, gyro, angle.
      if (frame.sum != rx_byte) begin
         status_in = STATUS_BAD_SUM;
      end else if (frame.type_code == codes.accel_code) begin
         status_in = STATUS_ACCEL;
      end else if (frame.type_code == codes.gyro_code) begin
         status_in = STATUS_GYRO;
      end else if (frame.type_code == codes.angle_code) begin
         status_in = STATUS_ANGLE;
      end else begin
         status_in = STATUS_UNKNOWN;
      end
      if (load && status_in == STATUS_ANGLE) begin
         angle_cnt_in = angle_cnt_ff + 32'd1;
         roll_in      = to_tenths(frame.word_zero);
         pitch_in     = to_tenths(frame.word_one);
         yaw_in       = to_tenths(frame.word_two);
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         byte_cnt_ff  <= 32'd0;
         angle_cnt_ff <= 32'd0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
      end else begin
         valid_ff     <= valid_in;
         byte_cnt_ff  <= byte_cnt_in;
         angle_cnt_ff <= angle_cnt_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
      end
      if (load) begin
         status_ff     <= status_in;
         w0_ff         <= frame.word_zero;
         w1_ff         <= frame.word_one;
         w2_ff         <= frame.word_two;
         w3_ff         <= frame.word_three;
         out_roll_ff   <= roll_in;
         out_pitch_ff  <= pitch_in;
         out_yaw_ff    <= yaw_in;
         out_bytes_ff  <= byte_cnt_in;
         out_angles_ff <= angle_cnt_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_frame_status      = status_ff;
   assign rsp_word_zero         = w0_ff;
   assign rsp_word_one          = w1_ff;
   assign rsp_word_two          = w2_ff;
   assign rsp_word_three        = w3_ff;
   assign rsp_roll_tenths       = out_roll_ff;
   assign rsp_pitch_tenths      = out_pitch_ff;
   assign rsp_yaw_tenths        = out_yaw_ff;
   assign rsp_bytes_received    = out_bytes_ff;
   assign rsp_angle_frames_seen = out_angles_ff;

   // A result appears only after a checksum byte has been taken.
   a_result_needs_check: assert property (@(posedge clock) disable iff (reset)
      !load && !(valid_ff && rsp_stall) |=> !valid_ff)
      else $error("result appeared without a checksum byte");

   // The reported byte count is the running count including the checksum byte.
   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_bytes_received == byte_cnt_ff)
      else $error("reported byte count disagrees with the running count");

   // The angle counter moves exactly on good angle frames.
   a_angle_count: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_angle_frames_seen ==
               $past(angle_cnt_ff) + {31'd0, rsp_frame_status == STATUS_ANGLE})
      else $error("angle frame counter out of step with status");

   // Stored roll and yaw angles change only on a good angle frame.
   a_angles_hold: assert property (@(posedge clock) disable iff (reset)
      !(load && status_in == STATUS_ANGLE) |=> $stable(roll_ff) && $stable(yaw_ff))
      else $error("stored angles changed outside an angle frame");

endmodule

// ===== src/imu_serial_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser core
// Parses 11-byte sensor frames from a serial byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per request, one per clock cycle when offered.
// Only the checksum byte of a frame produces a result, which is registered
// and shown on the rsp_ side in the cycle after that byte is taken. Header
// hunting, byte storage and the checksum are updated one byte at a time, so
// the rate is one byte per cycle; the only stall comes from a checksum byte
// that arrives while an earlier result still waits in the result register.
// Configuration writes are always ready; out-of-range indices are ignored.
module imu_serial_frame_parser_core
   import imu_sfp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_frame_status,
   output logic signed [15:0]         rsp_word_zero,
   output logic signed [15:0]         rsp_word_one,
   output logic signed [15:0]         rsp_word_two,
   output logic signed [15:0]         rsp_word_three,
   output logic signed [11:0]         rsp_roll_tenths,
   output logic signed [11:0]         rsp_pitch_tenths,
   output logic signed [11:0]         rsp_yaw_tenths,
   output logic [31:0]                rsp_bytes_received,
   output logic [31:0]                rsp_angle_frames_seen,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_wdata
);

   codes_type codes_ff;
   frame_type frame;
   logic      req_accept;

   assign csr_ready  = 1'b1;
   // Only the checksum byte needs the result register to be free.
   assign req_stall  = rsp_valid && rsp_stall && frame.at_check;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.accel_code <= ACCEL_CODE_RESET;
         codes_ff.gyro_code  <= GYRO_CODE_RESET;
         codes_ff.angle_code <= ANGLE_CODE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ACCEL_CODE: codes_ff.accel_code <= csr_wdata;
            REG_GYRO_CODE:  codes_ff.gyro_code  <= csr_wdata;
            REG_ANGLE_CODE: codes_ff.angle_code <= csr_wdata;
            default: ;
         endcase
      end
   end

   imu_sfp_collector u_collector (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .frame   (frame)
   );

   imu_sfp_decoder u_decoder (
      .clock                 (clock),
      .reset                 (reset),
      .accept                (req_accept),
      .rx_byte               (req_rx_byte),
      .frame                 (frame),
      .codes                 (codes_ff),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_frame_status      (rsp_frame_status),
      .rsp_word_zero         (rsp_word_zero),
      .rsp_word_one          (rsp_word_one),
      .rsp_word_two          (rsp_word_two),
      .rsp_word_three        (rsp_word_three),
      .rsp_roll_tenths       (rsp_roll_tenths),
      .rsp_pitch_tenths      (rsp_pitch_tenths),
      .rsp_yaw_tenths        (rsp_yaw_tenths),
      .rsp_bytes_received    (rsp_bytes_received),
      .rsp_angle_frames_seen (rsp_angle_frames_seen)
   );

   // The input is held back only while a result is waiting to be taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && frame.at_check)
      else $error("request stalled without a pending result");

   // A held result is not overwritten by a new frame.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bytes_received))
      else $error("pending result overwritten");

   // A stalled checksum byte is taken once the result register drains.
   a_drain_then_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && frame.at_check && !rsp_stall |-> req_accept)
      else $error("checksum byte refused with a free result register");

endmodule

// ===== tb/sv/imu_serial_frame_parser_core_test.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser core testbench
// Feeds serial byte streams of framed and stray bytes into the parser. A
// running model of the parser predicts each frame result, and every result
// taken from the block is compared with it, under several type code settings,
// random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_core_test
   import imu_sfp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_CYCLES     = 400;
   localparam int DEG_TENTHS_SPAN = 1800;
   localparam int RAW_FULL_SCALE  = 32768;
   localparam int DRAIN_CYCLES    = 4;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] word_zero;
      logic signed [15:0] word_one;
      logic signed [15:0] word_two;
      logic signed [15:0] word_three;
      logic signed [11:0] roll;
      logic signed [11:0] pitch;
      logic signed [11:0] yaw;
      logic [31:0]        byte_total;
      logic [31:0]        angle_total;
   } parsed_frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_rx_byte = 8'h00;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [2:0]                 rsp_frame_status;
   logic signed [15:0]         rsp_word_zero;
   logic signed [15:0]         rsp_word_one;
   logic signed [15:0]         rsp_word_two;
   logic signed [15:0]         rsp_word_three;
   logic signed [11:0]         rsp_roll_tenths;
   logic signed [11:0]         rsp_pitch_tenths;
   logic signed [11:0]         rsp_yaw_tenths;
   logic [31:0]                rsp_bytes_received;
   logic [31:0]                rsp_angle_frames_seen;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = '0;
   logic [7:0]                 csr_wdata   = 8'h00;

   // Stimulus control and bookkeeping.
   logic [7:0]       pending_bytes [$];
   parsed_frame_type frames_due [$];
   int               bytes_queued = 0;
   int               bytes_taken  = 0;
   int               mismatches   = 0;
   int               cycle_count  = 0;
   logic             idling_on    = 1'b1;
   logic             pressure_on  = 1'b0;
   int               send_gap     = 0;
   int               stall_left   = 0;
   logic             burst_stall  = 1'b0;
   int               hold_left    = 0;
   logic             hold_active  = 1'b0;
   logic             hold_done    = 1'b0;

   // Parser model state.
   logic [7:0]         code_accel = ACCEL_CODE_RESET;
   logic [7:0]         code_gyro  = GYRO_CODE_RESET;
   logic [7:0]         code_angle = ANGLE_CODE_RESET;
   logic [7:0]         held_bytes [10];
   logic [3:0]         slot        = '0;
   logic signed [15:0] angle_raw [3] = '{16'sd0, 16'sd0, 16'sd0};
   logic [31:0]        rx_count    = '0;
   logic [31:0]        angle_count = '0;

   assign rsp_stall = burst_stall | hold_active;

   imu_serial_frame_parser_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_frame_status      (rsp_frame_status),
      .rsp_word_zero         (rsp_word_zero),
      .rsp_word_one          (rsp_word_one),
      .rsp_word_two          (rsp_word_two),
      .rsp_word_three        (rsp_word_three),
      .rsp_roll_tenths       (rsp_roll_tenths),
      .rsp_pitch_tenths      (rsp_pitch_tenths),
      .rsp_yaw_tenths        (rsp_yaw_tenths),
      .rsp_bytes_received    (rsp_bytes_received),
      .rsp_angle_frames_seen (rsp_angle_frames_seen),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Truncation toward zero matters for small negative angles.
   function automatic logic signed [11:0] angle_tenths(input logic signed [15:0] raw);
      int scaled;
      scaled = (int'(raw) * DEG_TENTHS_SPAN) / RAW_FULL_SCALE;
      return scaled[11:0];
   endfunction

   task automatic track_rx_byte(input logic [7:0] rx);
      logic [7:0]         sum;
      logic signed [15:0] w [4];
      parsed_frame_type   r;
      rx_count = rx_count + 32'd1;
      if (slot == 4'd0 && rx != HEADER_BYTE) return;
      if (slot < CHECK_POS) begin
         held_bytes[slot] = rx;
         slot = slot + 4'd1;
         return;
      end
      slot = 4'd0;
      sum  = 8'h00;
      for (int i = 0; i < 10; i++) sum = sum + held_bytes[i];
      for (int i = 0; i < 4; i++) w[i] = {held_bytes[3 + 2 * i], held_bytes[2 + 2 * i]};
      if (sum != rx) begin
         r.status = STATUS_BAD_SUM;
      end else if (held_bytes[1] == code_accel) begin
         r.status = STATUS_ACCEL;
      end else if (held_bytes[1] == code_gyro) begin
         r.status = STATUS_GYRO;
      end else if (held_bytes[1] == code_angle) begin
         for (int i = 0; i < 3; i++) angle_raw[i] = w[i];
         angle_count = angle_count + 32'd1;
         r.status = STATUS_ANGLE;
      end else begin
         r.status = STATUS_UNKNOWN;
      end
      r.word_zero   = w[0];
      r.word_one    = w[1];
      r.word_two    = w[2];
      r.word_three  = w[3];
      r.roll        = angle_tenths(angle_raw[0]);
      r.pitch       = angle_tenths(angle_raw[1]);
      r.yaw         = angle_tenths(angle_raw[2]);
      r.byte_total  = rx_count;
      r.angle_total = angle_count;
      frames_due.push_back(r);
   endtask

   task automatic check_frame_result();
      parsed_frame_type want;
      logic             ok;
      if (frames_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected frame result: status %0d bytes %0d",
                     rsp_frame_status, rsp_bytes_received);
         return;
      end
      want = frames_due.pop_front();
      ok = (rsp_frame_status === want.status);
      ok = ok && (rsp_word_zero === want.word_zero);
      ok = ok && (rsp_word_one === want.word_one);
      ok = ok && (rsp_word_two === want.word_two);
      ok = ok && (rsp_word_three === want.word_three);
      ok = ok && (rsp_roll_tenths === want.roll);
      ok = ok && (rsp_pitch_tenths === want.pitch);
      ok = ok && (rsp_yaw_tenths === want.yaw);
      ok = ok && (rsp_bytes_received === want.byte_total);
      ok = ok && (rsp_angle_frames_seen === want.angle_total);
      if (!ok) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("frame mismatch, expected: st %0d w %0d %0d %0d %0d %s",
                     want.status, want.word_zero, want.word_one, want.word_two,
                     want.word_three,
                     $sformatf("ang %0d %0d %0d n %0d %0d", want.roll, want.pitch,
                               want.yaw, want.byte_total, want.angle_total));
            $display("  actual:   st %0d w %0d %0d %0d %0d %s",
                     rsp_frame_status, rsp_word_zero, rsp_word_one, rsp_word_two,
                     rsp_word_three,
                     $sformatf("ang %0d %0d %0d n %0d %0d", rsp_roll_tenths,
                               rsp_pitch_tenths, rsp_yaw_tenths,
                               rsp_bytes_received, rsp_angle_frames_seen));
         end
      end
   endtask

   // Sender: holds a stalled request, otherwise offers the next byte or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            send_gap  <= $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         burst_stall <= 1'b0;
         stall_left  <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) burst_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         burst_stall <= 1'b1;
         stall_left  <= $urandom_range(1, 9);
      end
   end

   // One long hold-off on the result side while bytes keep coming.
   always @(posedge clock) begin
      if (reset) begin
         hold_active <= 1'b0;
         hold_left   <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1) hold_active <= 1'b0;
      end else if (pressure_on && !hold_done) begin
         hold_active <= 1'b1;
         hold_left   <= HOLD_CYCLES;
         hold_done   <= 1'b1;
      end
   end

   // Monitor: the accepted byte is modelled before any result is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            bytes_taken++;
            track_rx_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) check_frame_result();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("imu_serial_frame_parser_core verification failed");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_frame(input logic [7:0] kind, input logic [15:0] w0,
                              input logic [15:0] w1, input logic [15:0] w2,
                              input logic [15:0] w3, input logic spoil);
      logic [7:0] fb [11];
      logic [7:0] sum;
      fb[0] = HEADER_BYTE;
      fb[1] = kind;
      {fb[3], fb[2]} = w0;
      {fb[5], fb[4]} = w1;
      {fb[7], fb[6]} = w2;
      {fb[9], fb[8]} = w3;
      sum = 8'h00;
      for (int i = 0; i < 10; i++) sum = sum + fb[i];
      fb[10] = spoil ? sum + 8'($urandom_range(1, 255)) : sum;
      for (int i = 0; i < 11; i++) queue_byte(fb[i]);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         4:       return 16'($signed(-$urandom_range(1, 40)));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_kind();
      case ($urandom_range(0, 3))
         0:       return code_accel;
         1:       return code_gyro;
         2:       return code_angle;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly well-formed frames, with some line noise, cut-off frames and
   // corrupted checksums mixed in.
   task automatic queue_traffic(input int n);
      int made;
      int pick;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
         end else if (pick < 16) begin
            queue_byte(HEADER_BYTE);
            repeat ($urandom_range(1, 9)) queue_byte(8'($urandom));
            made += 5;
         end else begin
            queue_frame(pick_kind(), pick_word(), pick_word(), pick_word(), pick_word(),
                        pick < 26);
            made += 11;
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [7:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_ACCEL_CODE: code_accel = data;
         REG_GYRO_CODE:  code_gyro  = data;
         REG_ANGLE_CODE: code_angle = data;
         default: ;
      endcase
   endtask

   task automatic write_codes(input logic [7:0] a, input logic [7:0] g, input logic [7:0] n);
      write_csr(REG_ACCEL_CODE, a);
      write_csr(REG_GYRO_CODE, g);
      write_csr(REG_ANGLE_CODE, n);
   endtask

   task automatic wait_drained();
      while (bytes_taken != bytes_queued || frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Stray bytes while hunting, then frames at the extremes. The accel
      // frame carries a header value as plain data, and the small negative
      // angle must truncate to zero rather than minus one.
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_frame(ACCEL_CODE_RESET, 16'h8000, 16'h7FFF, 16'h5555, 16'hFFFF, 1'b0);
      queue_frame(ANGLE_CODE_RESET, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
      queue_frame(8'h00, 16'h1234, 16'hEDCB, 16'h0001, 16'h8001, 1'b0);
      queue_frame(GYRO_CODE_RESET, 16'h7FFF, 16'h8000, 16'hFFED, 16'h0055, 1'b1);
      wait_drained();

      queue_traffic(110);
      wait_drained();

      write_codes(8'h00, 8'hFF, HEADER_BYTE);
      queue_traffic(90);
      wait_drained();

      // All codes equal, so accel takes precedence; out-of-range indices
      // must leave the codes alone.
      write_codes(8'h80, 8'h80, 8'h80);
      write_csr(8'd3, 8'($urandom));
      write_csr(8'hFF, 8'hFF);
      queue_traffic(60);
      wait_drained();

      write_codes(8'h10, 8'h20, 8'h20);
      queue_traffic(60);
      wait_drained();

      write_codes(ACCEL_CODE_RESET, GYRO_CODE_RESET, ANGLE_CODE_RESET);
      pressure_on <= 1'b1;
      repeat (8) queue_frame(pick_kind(), pick_word(), pick_word(), pick_word(),
                             pick_word(), 1'b0);
      wait_drained();
      pressure_on <= 1'b0;

      idling_on <= 1'b0;
      write_codes(8'($urandom), 8'($urandom), 8'($urandom));
      queue_traffic(100);
      wait_drained();
      repeat (8) @(posedge clock);

      if (mismatches == 0 && frames_due.size() == 0) begin
         $display("imu_serial_frame_parser_core verification clean");
      end else begin
         $display("imu_serial_frame_parser_core verification failed");
      end
      $finish;
   end

endmodule
